@@ src/wsbd_pkg.sv @@
package wsbd_pkg;

  // Store geometry
  localparam int DEPTH        = 64;
  localparam int STOLEN_DEPTH = 64;
  localparam int MAX_RUN      = 32;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int SPTR_W       = $clog2(STOLEN_DEPTH);
  localparam int CNT_W        = 7;
  localparam int ID_W         = 16;
  localparam int RUN_W        = $clog2(MAX_RUN + 1);

  // Request modes
  localparam logic [3:0] MODE_ADD        = 4'd0;
  localparam logic [3:0] MODE_TAKE_FRONT = 4'd1;
  localparam logic [3:0] MODE_TAKE_BACK  = 4'd2;
  localparam logic [3:0] MODE_STEAL_HALF = 4'd3;
  localparam logic [3:0] MODE_REMOVE_OLD = 4'd4;
  localparam logic [3:0] MODE_REWIND     = 4'd5;
  localparam logic [3:0] MODE_PUSH_STOLE = 4'd6;
  localparam logic [3:0] MODE_POP_STOLE  = 4'd7;
  localparam logic [3:0] MODE_CLEAR      = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [ID_W-1:0]  id_t;

endpackage

@@ src/wsbd_ram.sv @@
module wsbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/work_stealing_batch_deque.sv @@
// Timing: add, push stolen, rewind, clear and every refused request give their result
//   registered in the cycle after the transfer, and the block stays idle for the next request.
// Take front/back, remove oldest and pop stolen go through the store's registered read:
//   the store's read register and then the output register lie between transfer and result.
// Steal half streams n ids, one per cycle, through the store read port.
// Synchronous active-low reset empties list, window and stolen stack; threshold resets to 1.
module work_stealing_batch_deque
  import wsbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [3:0]       in_mode,
  input  logic [ID_W-1:0]  in_batch_id,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [ID_W-1:0]  out_batch,
  output logic             out_last,
  output logic [CNT_W-1:0] out_remaining
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic       state_r, state_nxt;
  ptr_t       head_r, head_nxt;
  cnt_t       list_count_r, list_count_nxt;
  cnt_t       front_r, front_nxt;
  cnt_t       back_r, back_nxt;
  cnt_t       exec_r, exec_nxt;
  cnt_t       stolen_count_r, stolen_count_nxt;
  cnt_t       thresh_r;
  logic [RUN_W-1:0] run_left_r, run_left_nxt;
  ptr_t       run_addr_r, run_addr_nxt;
  logic       src_stolen_r, src_stolen_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  id_t        out_batch_r, out_batch_nxt;
  logic       out_last_r, out_last_nxt;
  cnt_t       out_rem_r, out_rem_nxt;

  logic              b_we, s_we;
  ptr_t              b_waddr, b_raddr;
  logic [SPTR_W-1:0] s_waddr, s_raddr;
  id_t               b_rdata, s_rdata;
  logic              accept;
  cnt_t              half;
  logic [RUN_W-1:0]  steal_n;
  cnt_t              back_less_n;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_RUN);

  // Run length of a steal half, capped
  assign half        = exec_r >> 1;
  assign steal_n     = (half > cnt_t'(MAX_RUN)) ? RUN_W'(MAX_RUN) : RUN_W'(half);
  assign back_less_n = back_r - cnt_t'(steal_n);

  wsbd_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_batch_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (in_batch_id),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  wsbd_ram #(.WIDTH(ID_W), .DEPTH(STOLEN_DEPTH)) u_stolen_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (in_batch_id),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Decode requests, update counters, steer store ports
  always_comb begin
    state_nxt        = state_r;
    head_nxt         = head_r;
    list_count_nxt   = list_count_r;
    front_nxt        = front_r;
    back_nxt         = back_r;
    exec_nxt         = exec_r;
    stolen_count_nxt = stolen_count_r;
    run_left_nxt     = run_left_r;
    run_addr_nxt     = run_addr_r;
    src_stolen_nxt   = src_stolen_r;
    out_valid_nxt    = 1'b0;
    out_status_nxt   = ST_DONE;
    out_batch_nxt    = '0;
    out_last_nxt     = 1'b1;
    out_rem_nxt      = exec_r;
    b_we             = 1'b0;
    s_we             = 1'b0;
    b_waddr          = head_r + ptr_t'(list_count_r);
    s_waddr          = stolen_count_r[SPTR_W-1:0];
    b_raddr          = run_addr_r;
    s_raddr          = run_addr_r[SPTR_W-1:0];

    if (state_r == S_RUN) begin
      // Stream one read result per cycle, issue the next read
      out_valid_nxt = 1'b1;
      out_batch_nxt = src_stolen_r ? s_rdata : b_rdata;
      out_last_nxt  = (run_left_r == RUN_W'(1));
      run_addr_nxt  = run_addr_r + ptr_t'(1);
      run_left_nxt  = run_left_r - RUN_W'(1);
      if (run_left_r == RUN_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      case (in_mode)
        MODE_ADD: begin
          if (list_count_r >= cnt_t'(DEPTH)) begin
            out_status_nxt = ST_FULL;
          end else begin
            b_we           = 1'b1;
            list_count_nxt = list_count_r + cnt_t'(1);
            back_nxt       = back_r + cnt_t'(1);
            exec_nxt       = exec_r + cnt_t'(1);
          end
        end
        MODE_TAKE_FRONT: begin
          if (exec_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            b_raddr        = head_r + ptr_t'(front_r);
            front_nxt      = front_r + cnt_t'(1);
            exec_nxt       = exec_r - cnt_t'(1);
            out_valid_nxt  = 1'b0;
            state_nxt      = S_RUN;
            run_left_nxt   = RUN_W'(1);
            src_stolen_nxt = 1'b0;
          end
        end
        MODE_TAKE_BACK: begin
          if (exec_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            b_raddr        = head_r + ptr_t'(back_r - cnt_t'(1));
            back_nxt       = back_r - cnt_t'(1);
            exec_nxt       = exec_r - cnt_t'(1);
            out_valid_nxt  = 1'b0;
            state_nxt      = S_RUN;
            run_left_nxt   = RUN_W'(1);
            src_stolen_nxt = 1'b0;
          end
        end
        MODE_STEAL_HALF: begin
          if (exec_r <= thresh_r || steal_n == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            b_raddr        = head_r + ptr_t'(back_less_n);
            run_addr_nxt   = head_r + ptr_t'(back_less_n) + ptr_t'(1);
            back_nxt       = back_less_n;
            exec_nxt       = exec_r - cnt_t'(steal_n);
            out_valid_nxt  = 1'b0;
            state_nxt      = S_RUN;
            run_left_nxt   = steal_n;
            src_stolen_nxt = 1'b0;
          end
        end
        MODE_REMOVE_OLD: begin
          if (list_count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            b_raddr        = head_r;
            head_nxt       = head_r + ptr_t'(1);
            list_count_nxt = list_count_r - cnt_t'(1);
            if (front_r != '0) begin
              front_nxt = front_r - cnt_t'(1);
              back_nxt  = back_r - cnt_t'(1);
            end else if (back_r != '0) begin
              back_nxt = back_r - cnt_t'(1);
              exec_nxt = exec_r - cnt_t'(1);
            end
            out_valid_nxt  = 1'b0;
            state_nxt      = S_RUN;
            run_left_nxt   = RUN_W'(1);
            src_stolen_nxt = 1'b0;
          end
        end
        MODE_REWIND: begin
          front_nxt        = '0;
          back_nxt         = list_count_r;
          exec_nxt         = list_count_r;
          stolen_count_nxt = '0;
        end
        MODE_PUSH_STOLE: begin
          if (stolen_count_r >= cnt_t'(STOLEN_DEPTH)) begin
            out_status_nxt = ST_FULL;
          end else begin
            s_we             = 1'b1;
            stolen_count_nxt = stolen_count_r + cnt_t'(1);
          end
        end
        MODE_POP_STOLE: begin
          if (stolen_count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            s_raddr          = SPTR_W'(stolen_count_r - cnt_t'(1));
            stolen_count_nxt = stolen_count_r - cnt_t'(1);
            out_valid_nxt    = 1'b0;
            state_nxt        = S_RUN;
            run_left_nxt     = RUN_W'(1);
            src_stolen_nxt   = 1'b1;
          end
        end
        MODE_CLEAR: begin
          head_nxt       = '0;
          list_count_nxt = '0;
          front_nxt      = '0;
          back_nxt       = '0;
          exec_nxt       = '0;
        end
        default: begin
          out_status_nxt = ST_EMPTY;
        end
      endcase
      out_rem_nxt = exec_nxt;
    end
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      head_r         <= '0;
      list_count_r   <= '0;
      front_r        <= '0;
      back_r         <= '0;
      exec_r         <= '0;
      stolen_count_r <= '0;
      thresh_r       <= cnt_t'(1);
      run_left_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      head_r         <= head_nxt;
      list_count_r   <= list_count_nxt;
      front_r        <= front_nxt;
      back_r         <= back_nxt;
      exec_r         <= exec_nxt;
      stolen_count_r <= stolen_count_nxt;
      run_left_r     <= run_left_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
    end
  end

  // Result payload and run bookkeeping
  always_ff @(posedge clk) begin
    run_addr_r   <= run_addr_nxt;
    src_stolen_r <= src_stolen_nxt;
    out_status_r <= out_status_nxt;
    out_batch_r  <= out_batch_nxt;
    out_last_r   <= out_last_nxt;
    out_rem_r    <= out_rem_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_batch     = out_batch_r;
  assign out_last      = out_last_r;
  assign out_remaining = out_rem_r;

  // Window bookkeeping stays consistent
  a_exec_span: assert property (@(posedge clk) disable iff (!rst_n)
    exec_r == back_r - front_r)
    else $error("exec count differs from window span");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    list_count_r <= cnt_t'(DEPTH) && back_r <= list_count_r)
    else $error("list or window exceeds store");

  a_run_left: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> run_left_r != '0)
    else $error("busy with nothing left to stream");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_batch == '0 && out_last)
    else $error("refused result carries an id or is not last");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    busy && run_left_r == RUN_W'(1) |=> out_valid && out_last && !busy)
    else $error("run did not end with a last result");

endmodule
